// ----- rtl/core/lru_tlb_miss_counter_macros.svh -----
// Assertion macros shared by the TLB miss counter RTL.
`ifndef LRU_TLB_MISS_COUNTER_MACROS_SVH
`define LRU_TLB_MISS_COUNTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LTMC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LTMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/ltmc_pkg.sv -----
// Shared constants and types for the LRU TLB miss counter.
`timescale 1ns / 1ps

package ltmc_pkg;

    // Table geometry and field widths.
    localparam int ENTRIES   = 16;
    localparam int ADDR_BITS = 48;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int RANK_W    = IDX_W;
    localparam int CNT_W     = 32;
    localparam int PSZ_W     = 31;
    localparam int DIV_CNT_W = $clog2(ADDR_BITS + 1);

    // Stream word widths, padded to whole bytes.
    localparam int S_TDATA_W = ((ADDR_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((1 + CNT_W + 7) / 8) * 8;

    // Reset page size and counter ceiling.
    localparam logic [PSZ_W-1:0] PSZ_RESET = PSZ_W'(4096);
    localparam logic [CNT_W-1:0] CNT_MAX   = '1;

    // Command codes carried in tuser.
    localparam logic CMD_ACCESS = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_DIV    = 3'b010,
        S_UPDATE = 3'b100
    } t_state;

endpackage

// ----- rtl/core/ltmc_divider.sv -----
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module ltmc_divider (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [ltmc_pkg::ADDR_BITS-1:0]      i_dividend,
    input  logic [ltmc_pkg::PSZ_W-1:0]          i_divisor,
    output logic                                o_done,
    output logic [ltmc_pkg::ADDR_BITS-1:0]      o_quotient
);

    logic                                r_busy;
    logic                                r_done;
    logic [ltmc_pkg::DIV_CNT_W-1:0]      r_cnt;
    logic [ltmc_pkg::ADDR_BITS-1:0]      r_quot;
    logic [ltmc_pkg::PSZ_W-1:0]          r_rem;
    logic [ltmc_pkg::PSZ_W-1:0]          r_dvs;
    logic [ltmc_pkg::PSZ_W:0]            rem_sh;
    logic [ltmc_pkg::PSZ_W+1:0]          diff;
    logic                                ge;

    // Shift in the next dividend bit and trial-subtract the divisor.
    always_comb begin
        rem_sh = {r_rem, r_quot[ltmc_pkg::ADDR_BITS-1]};
        diff   = {1'b0, rem_sh} - {2'b00, r_dvs};
        ge     = ~diff[ltmc_pkg::PSZ_W+1];
    end

    // Iteration control; a zero divisor is taken as one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= ltmc_pkg::DIV_CNT_W'(ltmc_pkg::ADDR_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == ltmc_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Quotient and partial remainder datapath.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= (i_divisor == '0) ? ltmc_pkg::PSZ_W'(1) : i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[ltmc_pkg::ADDR_BITS-2:0], ge};
            r_rem  <= ge ? diff[ltmc_pkg::PSZ_W-1:0] : rem_sh[ltmc_pkg::PSZ_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quot;

endmodule

// ----- rtl/core/lru_tlb_miss_counter.sv -----
// LRU TLB miss counter: top level with the lookup table and sequencer.
// Each input word is either an access (tuser = 0) or a clear (tuser = 1). An access
// divides its byte address by the page size register in a shared restoring divider
// that yields one quotient bit per clock. Its result word appears after the divider
// iterations, the hand-over of the page number and the table update; the block is
// ready again in the same cycle that the result word appears. A clear skips the
// divider and goes straight to the table update. The block takes one word at a time
// and is not ready while a word is in flight, but it accepts a new word while the
// previous result still waits on the output; a word that finishes while that result
// is still waiting stalls in the update step until the output is taken.
// The page size register may be written only while the block is idle; a
// value of zero acts as one. Every input word yields exactly one output word.
`timescale 1ns / 1ps

module lru_tlb_miss_counter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration: page size in bytes.
    input  logic                                i_cfg_wr_en,
    input  logic [ltmc_pkg::PSZ_W-1:0]          i_cfg_wr_data,
    // Input stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [ltmc_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // byte_address
    input  logic [0:0]                          s_axis_tuser,  // cmd
    // Output stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [ltmc_pkg::M_TDATA_W-1:0]      m_axis_tdata   // hit, miss_total, zero pad
);

    localparam int LIM_W = ltmc_pkg::RANK_W + 1;

    ltmc_pkg::t_state                       r_state;
    ltmc_pkg::t_state                       n_state;
    logic [ltmc_pkg::PSZ_W-1:0]             r_page_size;
    logic                                   r_is_clear;
    logic [ltmc_pkg::ADDR_BITS-1:0]         r_page;
    logic [ltmc_pkg::ADDR_BITS-1:0]         r_tags [ltmc_pkg::ENTRIES];
    logic [ltmc_pkg::RANK_W-1:0]            r_rank [ltmc_pkg::ENTRIES];
    logic [ltmc_pkg::ENTRIES-1:0]           r_valid;
    logic [ltmc_pkg::CNT_W-1:0]             r_miss_cnt;
    logic                                   r_out_valid;
    logic                                   r_out_hit;
    logic [ltmc_pkg::CNT_W-1:0]             r_out_total;

    logic                                   in_fire;
    logic                                   in_clear;
    logic                                   div_start;
    logic                                   div_done;
    logic [ltmc_pkg::ADDR_BITS-1:0]         div_quot;
    logic                                   upd_go;
    logic [ltmc_pkg::ENTRIES-1:0]           match;
    logic [ltmc_pkg::ENTRIES-1:0]           oldest_vec;
    logic                                   hit;
    logic                                   full;
    logic [ltmc_pkg::IDX_W-1:0]             hit_idx;
    logic [ltmc_pkg::IDX_W-1:0]             free_idx;
    logic [ltmc_pkg::IDX_W-1:0]             old_idx;
    logic [ltmc_pkg::IDX_W-1:0]             slot;
    logic [LIM_W-1:0]                       limit;
    logic [ltmc_pkg::CNT_W-1:0]             cnt_next;

    // Handshake decode.
    assign s_axis_tready = (r_state == ltmc_pkg::S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_clear      = (s_axis_tuser[0] == ltmc_pkg::CMD_CLEAR);
    assign div_start     = in_fire && !in_clear;
    assign upd_go        = (r_state == ltmc_pkg::S_UPDATE) && (!r_out_valid || m_axis_tready);

    // Page size register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_size <= ltmc_pkg::PSZ_RESET;
        end else if (i_cfg_wr_en) begin
            r_page_size <= i_cfg_wr_data;
        end
    end

    // Shared divider turns the byte address into a page number.
    ltmc_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (s_axis_tdata[ltmc_pkg::ADDR_BITS-1:0]),
        .i_divisor  (r_page_size),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ltmc_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_state = in_clear ? ltmc_pkg::S_UPDATE : ltmc_pkg::S_DIV;
                end
            end
            ltmc_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = ltmc_pkg::S_UPDATE;
                end
            end
            ltmc_pkg::S_UPDATE: begin
                if (upd_go) begin
                    n_state = ltmc_pkg::S_IDLE;
                end
            end
            default: n_state = ltmc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ltmc_pkg::S_IDLE;
            r_is_clear <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_fire) begin
                r_is_clear <= in_clear;
            end
        end
    end

    // Hold the page number once the divider finishes.
    always_ff @(posedge i_clk) begin
        if (div_done) begin
            r_page <= div_quot;
        end
    end

    // Tag match, oldest entry and free entry searches over the table.
    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        old_idx  = '0;
        for (int i = 0; i < ltmc_pkg::ENTRIES; i++) begin
            match[i]      = r_valid[i] && (r_tags[i] == r_page);
            oldest_vec[i] = r_valid[i] &&
                            (r_rank[i] == ltmc_pkg::RANK_W'(ltmc_pkg::ENTRIES - 1));
        end
        for (int i = ltmc_pkg::ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_idx = ltmc_pkg::IDX_W'(i);
            end
            if (!r_valid[i]) begin
                free_idx = ltmc_pkg::IDX_W'(i);
            end
            if (oldest_vec[i]) begin
                old_idx = ltmc_pkg::IDX_W'(i);
            end
        end
        hit   = |match;
        full  = &r_valid;
        slot  = hit ? hit_idx : (full ? old_idx : free_idx);
        limit = hit ? {1'b0, r_rank[hit_idx]} : '1;
    end

    // Saturating miss count after this access.
    assign cnt_next = (r_miss_cnt == ltmc_pkg::CNT_MAX) ? r_miss_cnt : r_miss_cnt + 1'b1;

    // Table and counter update, once per word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_miss_cnt <= '0;
            for (int i = 0; i < ltmc_pkg::ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (upd_go) begin
            if (r_is_clear) begin
                r_valid    <= '0;
                r_miss_cnt <= '0;
                for (int i = 0; i < ltmc_pkg::ENTRIES; i++) begin
                    r_rank[i] <= '0;
                end
            end else begin
                // Younger entries age by one; the touched entry becomes newest.
                for (int i = 0; i < ltmc_pkg::ENTRIES; i++) begin
                    if (ltmc_pkg::IDX_W'(i) == slot) begin
                        r_rank[i] <= '0;
                    end else if (r_valid[i] && ({1'b0, r_rank[i]} < limit)) begin
                        r_rank[i] <= r_rank[i] + 1'b1;
                    end
                end
                if (!hit) begin
                    r_valid[slot] <= 1'b1;
                    r_miss_cnt    <= cnt_next;
                end
            end
        end
    end

    // Tag store, written only when a missing page is inserted.
    always_ff @(posedge i_clk) begin
        if (upd_go && !r_is_clear && !hit) begin
            r_tags[slot] <= r_page;
        end
    end

    // Output register holds the result word until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (upd_go) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd_go) begin
            if (r_is_clear) begin
                r_out_hit   <= 1'b0;
                r_out_total <= '0;
            end else begin
                r_out_hit   <= hit;
                r_out_total <= hit ? r_miss_cnt : cnt_next;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = ltmc_pkg::M_TDATA_W'({r_out_total, r_out_hit});

    // Checks on the table bookkeeping and the sequencer.
    `include "lru_tlb_miss_counter_macros.svh"

    `LTMC_ASSERT_NOW(a_full_one_oldest, i_clk, i_rst_n, full, $onehot(oldest_vec),
                     "full table lacks a unique oldest entry")
    `LTMC_ASSERT_NEXT(a_hit_keeps_count, i_clk, i_rst_n, upd_go && !r_is_clear && hit,
                      r_miss_cnt == $past(r_miss_cnt), "miss count changed on a hit")
    `LTMC_ASSERT_NEXT(a_valid_grows, i_clk, i_rst_n, upd_go && !r_is_clear,
                      $countones(r_valid) >= $past($countones(r_valid)),
                      "valid entries lost without a clear")
    `LTMC_ASSERT_NOW(a_div_done_state, i_clk, i_rst_n, div_done,
                     r_state == ltmc_pkg::S_DIV, "divider finished outside the divide state")

endmodule
